// File: src/srdz_pkg.sv
// Shared constants and types for the stick radial dead-zone unit.
// No dependencies; compile first.
package srdz_pkg;

  // Sample and register widths
  localparam int IN_W       = 16;
  localparam int DZ_W       = 15;
  localparam int FS_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [DZ_W-1:0] DZ_RESET = 15'd4000;
  localparam logic [FS_W-1:0] FS_RESET = 16'd32767;

  // Square root: 32-bit sum of squares, 16-bit root, two radicand bits per step
  localparam int SUM_W    = 32;
  localparam int ROOT_W   = 16;
  localparam int SQ_STEPS = ROOT_W;
  localparam int REM_W    = ROOT_W + 1;

  // Restoring divider: dividend, divisor, quotient widths (one quotient bit per stage)
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 16;
  localparam int DIV_QW = 16;

  // Fixed-point scaling of the results
  localparam int DIR_FRAC = 14;
  localparam int MAG_FRAC = 15;
  localparam int OUT_W    = 16;
  localparam logic [OUT_W-1:0] MAG_ONE = 16'd32768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE   = 1'b0,
    REG_FULL_SCALE = 1'b1
  } cfg_reg_t;

  // One result item
  typedef struct packed {
    logic                    active;
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic        [OUT_W-1:0] norm_magnitude;
  } res_t;

endpackage

// File: src/srdz_in_if.sv
// Sample channel interface (valid/ready plus stick_x, stick_y).
// Depends on srdz_pkg.
interface srdz_in_if import srdz_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] stick_x;
  logic signed [IN_W-1:0] stick_y;

  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

// File: src/srdz_out_if.sv
// Result channel interface (valid/ready plus direction, magnitude and active flag).
// Depends on srdz_pkg.
interface srdz_out_if import srdz_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    active;
  logic signed [OUT_W-1:0] dir_x;
  logic signed [OUT_W-1:0] dir_y;
  logic        [OUT_W-1:0] norm_magnitude;

  modport source (output valid, output active, output dir_x, output dir_y,
                  output norm_magnitude, input ready);
  modport sink   (input valid, input active, input dir_x, input dir_y,
                  input norm_magnitude, output ready);
endinterface

// File: src/srdz_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on srdz_pkg for default widths.
module srdz_div import srdz_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW,
  parameter int QW = DIV_QW
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int Sh = QW - 1 - i;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] den_sh;
    logic [CW-1:0] diff;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    always_comb begin
      rem_ext = CW'(rem_in);
      den_sh  = CW'(den_in) << Sh;
      diff    = rem_ext - den_sh;
      ge      = (rem_ext >= den_sh);
      rem_nxt = ge ? diff[NW-1:0] : rem_in;
      quo_nxt = quo_in;
      quo_nxt[Sh] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// File: src/stick_radial_deadzone_unit.sv
// Stick radial dead-zone unit: length, unit direction and normalized magnitude.
// Throughput: one sample per cycle while the skid buffer is empty; 1 squaring +
// 1 sum + 16 root + 1 setup + 16 divide stages, then an output register backed
// by a one-entry skid buffer. Reset (rst_n, synchronous, active low) clears all
// valid bits and loads the dead zone with 4000 and full scale with 32767.
// Depends on srdz_pkg, srdz_div.
module stick_radial_deadzone_unit import srdz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  srdz_in_if.sink               in_ch,
  srdz_out_if.source            out_ch
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline is
  // empty (the unit does not enforce it), so every stage may read them directly.
  // ---------------------------------------------------------------------------
  logic [DZ_W-1:0] deadzone_r;
  logic [FS_W-1:0] full_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r   <= DZ_RESET;
      full_scale_r <= FS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEADZONE:   deadzone_r   <= cfg_wdata[DZ_W-1:0];
        REG_FULL_SCALE: full_scale_r <= cfg_wdata[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together; only a full skid buffer
  // stops it, so a sample is taken while a result still waits at the output.
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_v_r;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: square both components (one 16x16 multiplier each).
  // ---------------------------------------------------------------------------
  logic signed [2*IN_W-1:0] px;
  logic signed [2*IN_W-1:0] py;
  logic                     s0_v_r;
  logic [SUM_W-2:0]         s0_sqx_r;
  logic [SUM_W-2:0]         s0_sqy_r;
  logic signed [IN_W-1:0]   s0_x_r;
  logic signed [IN_W-1:0]   s0_y_r;

  assign px = in_ch.stick_x * in_ch.stick_x;
  assign py = in_ch.stick_y * in_ch.stick_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sqx_r <= px[SUM_W-2:0];
      s0_sqy_r <= py[SUM_W-2:0];
      s0_x_r   <= in_ch.stick_x;
      s0_y_r   <= in_ch.stick_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root, digit by digit. Entry 0 holds the sum of squares with an
  // empty root; each following entry has resolved one more root bit.
  // ---------------------------------------------------------------------------
  logic                   sq_v_r    [SQ_STEPS+1];
  logic [SUM_W-1:0]       sq_sum_r  [SQ_STEPS+1];
  logic [REM_W-1:0]       sq_rem_r  [SQ_STEPS+1];
  logic [ROOT_W-1:0]      sq_root_r [SQ_STEPS+1];
  logic signed [IN_W-1:0] sq_x_r    [SQ_STEPS+1];
  logic signed [IN_W-1:0] sq_y_r    [SQ_STEPS+1];

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sum_r[0]  <= SUM_W'(s0_sqx_r) + SUM_W'(s0_sqy_r);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0]    <= s0_x_r;
      sq_y_r[0]    <= s0_y_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    // Bring down the next two radicand bits, try (root*4 + 1)
    always_comb begin
      cur   = {sq_rem_r[k], sq_sum_r[k][SUM_W-1-2*k -: 2]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_sum_r[k+1]  <= sq_sum_r[k];
        sq_rem_r[k+1]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_x_r[k+1]    <= sq_x_r[k];
        sq_y_r[k+1]    <= sq_y_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Setup stage: dead-zone test, clamping and divider operands.
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0]      len;
  logic signed [IN_W-1:0] sx_in;
  logic signed [IN_W-1:0] sy_in;
  logic [ROOT_W-1:0]      dz_ext;
  logic [ROOT_W-1:0]      clamp_len;
  logic [ROOT_W-1:0]      over_dz;
  logic [IN_W-1:0]        mag_x;
  logic [IN_W-1:0]        mag_y;

  assign len    = sq_root_r[SQ_STEPS];
  assign sx_in  = sq_x_r[SQ_STEPS];
  assign sy_in  = sq_y_r[SQ_STEPS];
  assign dz_ext = ROOT_W'(deadzone_r);

  always_comb begin
    clamp_len = (len > full_scale_r) ? full_scale_r : len;
    over_dz   = clamp_len - dz_ext;
    mag_x     = sx_in[IN_W-1] ? (~sx_in + 1'b1) : sx_in;
    mag_y     = sy_in[IN_W-1] ? (~sy_in + 1'b1) : sy_in;
  end

  logic              st_v_r;
  logic              st_act_r;
  logic              st_sat_r;
  logic              st_zero_r;
  logic              st_sx_r;
  logic              st_sy_r;
  logic [DIV_NW-1:0] st_numx_r;
  logic [DIV_NW-1:0] st_numy_r;
  logic [DIV_DW-1:0] st_len_r;
  logic [DIV_NW-1:0] st_numn_r;
  logic [DIV_DW-1:0] st_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else if (adv) begin
      st_v_r <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_act_r  <= (len > dz_ext);
      // Full scale at or below the dead zone: any active sample is past full scale
      st_sat_r  <= (full_scale_r <= dz_ext);
      st_zero_r <= (len == '0);
      st_sx_r   <= sx_in[IN_W-1];
      st_sy_r   <= sy_in[IN_W-1];
      st_numx_r <= DIV_NW'(mag_x) << DIR_FRAC;
      st_numy_r <= DIV_NW'(mag_y) << DIR_FRAC;
      st_len_r  <= DIV_DW'(len);
      st_numn_r <= DIV_NW'(over_dz) << MAG_FRAC;
      st_span_r <= DIV_DW'(full_scale_r - dz_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Three dividers in lockstep; flags ride along in a matching shift line.
  // ---------------------------------------------------------------------------
  logic [DIV_QW-1:0] quo_x;
  logic [DIV_QW-1:0] quo_y;
  logic [DIV_QW-1:0] quo_n;

  srdz_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_x (
    .clk (clk), .adv (adv), .num (st_numx_r), .den (st_len_r), .quo (quo_x)
  );

  srdz_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_y (
    .clk (clk), .adv (adv), .num (st_numy_r), .den (st_len_r), .quo (quo_y)
  );

  srdz_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_n (
    .clk (clk), .adv (adv), .num (st_numn_r), .den (st_span_r), .quo (quo_n)
  );

  logic sb_v_r    [DIV_QW];
  logic sb_act_r  [DIV_QW];
  logic sb_sat_r  [DIV_QW];
  logic sb_zero_r [DIV_QW];
  logic sb_sx_r   [DIV_QW];
  logic sb_sy_r   [DIV_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_QW; i++) sb_v_r[i] <= 1'b0;
    end else if (adv) begin
      sb_v_r[0] <= st_v_r;
      for (int i = 1; i < DIV_QW; i++) sb_v_r[i] <= sb_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_act_r[0]  <= st_act_r;
      sb_sat_r[0]  <= st_sat_r;
      sb_zero_r[0] <= st_zero_r;
      sb_sx_r[0]   <= st_sx_r;
      sb_sy_r[0]   <= st_sy_r;
      for (int i = 1; i < DIV_QW; i++) begin
        sb_act_r[i]  <= sb_act_r[i-1];
        sb_sat_r[i]  <= sb_sat_r[i-1];
        sb_zero_r[i] <= sb_zero_r[i-1];
        sb_sx_r[i]   <= sb_sx_r[i-1];
        sb_sy_r[i]   <= sb_sy_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result formatting: restore signs, drop direction on zero length, gate
  // magnitude with the active flag and force it to 1.0 when saturated.
  // ---------------------------------------------------------------------------
  logic pipe_v;
  res_t res;

  assign pipe_v = sb_v_r[DIV_QW-1];

  always_comb begin
    res.active = sb_act_r[DIV_QW-1];
    if (sb_zero_r[DIV_QW-1]) begin
      res.dir_x = '0;
      res.dir_y = '0;
    end else begin
      res.dir_x = sb_sx_r[DIV_QW-1] ? (~quo_x + 1'b1) : quo_x;
      res.dir_y = sb_sy_r[DIV_QW-1] ? (~quo_y + 1'b1) : quo_y;
    end
    if (!sb_act_r[DIV_QW-1]) begin
      res.norm_magnitude = '0;
    end else if (sb_sat_r[DIV_QW-1]) begin
      res.norm_magnitude = MAG_ONE;
    end else begin
      res.norm_magnitude = quo_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a one-entry skid buffer. When the output is held, the
  // result leaving the pipeline parks in the skid entry and the pipeline holds
  // until it drains.
  // ---------------------------------------------------------------------------
  logic out_v_r;
  res_t out_res_r;
  res_t skid_res_r;
  logic out_held;
  logic drain;
  logic load_out;
  logic load_skid;
  logic out_v_nxt;
  logic skid_v_nxt;

  always_comb begin
    out_held   = out_v_r && !out_ch.ready;
    drain      = skid_v_r && out_ch.ready;
    load_out   = adv && !out_held;
    load_skid  = adv && out_held && pipe_v;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (drain) begin
      out_v_nxt  = 1'b1;
      skid_v_nxt = 1'b0;
    end else begin
      if (load_out)  out_v_nxt  = pipe_v;
      if (load_skid) skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_res_r <= skid_res_r;
    end else if (load_out) begin
      out_res_r <= res;
    end
    if (load_skid) begin
      skid_res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.active         = out_res_r.active;
  assign out_ch.dir_x          = out_res_r.dir_x;
  assign out_ch.dir_y          = out_res_r.dir_y;
  assign out_ch.norm_magnitude = out_res_r.norm_magnitude;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for stick_radial_deadzone_unit: samples go in, checked results come out.
// Depends on srdz_pkg, srdz_in_if, srdz_out_if and the unit itself.
module tb;
  import srdz_pkg::*;

  localparam int STALL_LIMIT  = 3000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 40;    // idle watch after the final drain
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 43;

  // One result still owed by the unit, with the sample that caused it
  typedef struct {
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    res_t                   want;
  } pending_t;

  // One directed sample and the register setting it runs under
  typedef struct {
    logic [CFG_DATA_W-1:0]  dz_w;
    logic [CFG_DATA_W-1:0]  fs_w;
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    bit                     typed;
    res_t                   want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  srdz_in_if  in_ch ();
  srdz_out_if out_ch ();

  stick_radial_deadzone_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  // Bench copy of the two registers, as the unit holds them
  logic [DZ_W-1:0]       dz_model;
  logic [FS_W-1:0]       fs_model;
  // Raw words last written, so the directed table only writes on a change
  logic [CFG_DATA_W-1:0] dz_written;
  logic [CFG_DATA_W-1:0] fs_written;

  pending_t pending_results[$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  int       burst_left;
  int       gap_left;

  logic signed [IN_W-1:0] corners [6] = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1,
                                          16'sd32767};

  // Register settings for the random phases; entries 7 and 8 are drawn at run time.
  // Raw words: bit 15 of the dead zone is dropped by the unit.
  logic [CFG_DATA_W-1:0] phase_dz [PHASES] = '{16'd0, 16'hFFFF, 16'd0, 16'd5000, 16'd20000,
                                               16'd32767, 16'h84D2, 16'd0, 16'd0, 16'd4000};
  logic [CFG_DATA_W-1:0] phase_fs [PHASES] = '{16'd1, 16'd0, 16'd46341, 16'd5000, 16'd10000,
                                               16'd65535, 16'd30000, 16'd0, 16'd0, 16'd32767};

  // Directed samples. Rows with typed set carry a hand-worked result; the rest go
  // through the predictor. Covers axis and diagonal extremes, zero length, the dead
  // zone edge, full scale at or below the dead zone, and masked register bits.
  row_t script [25] = '{
    '{16'd4000, 16'd32767, 16'sd0, 16'sd0, 1'b1, '{1'b0, 16'sd0, 16'sd0, 16'd0}},
    '{16'd4000, 16'd32767, 16'sd32767, 16'sd0, 1'b1, '{1'b1, 16'sd16384, 16'sd0, 16'd32768}},
    '{16'd4000, 16'd32767, 16'sh8000, 16'sd0, 1'b1, '{1'b1, -16'sd16384, 16'sd0, 16'd32768}},
    '{16'd4000, 16'd32767, 16'sd0, 16'sd32767, 1'b1, '{1'b1, 16'sd0, 16'sd16384, 16'd32768}},
    '{16'd4000, 16'd32767, 16'sd0, 16'sh8000, 1'b1, '{1'b1, 16'sd0, -16'sd16384, 16'd32768}},
    '{16'd4000, 16'd32767, 16'sh8000, 16'sh8000, 1'b1,
      '{1'b1, -16'sd11585, -16'sd11585, 16'd32768}},
    '{16'd4000, 16'd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'd4000, 16'd32767, 16'sd4000, 16'sd0, 1'b1, '{1'b0, 16'sd16384, 16'sd0, 16'd0}},
    '{16'd4000, 16'd32767, 16'sd4001, 16'sd0, 1'b1, '{1'b1, 16'sd16384, 16'sd0, 16'd1}},
    '{16'd4000, 16'd32767, 16'sd0, -16'sd4000, 1'b1, '{1'b0, 16'sd0, -16'sd16384, 16'd0}},
    '{16'd4000, 16'd32767, 16'sd3, 16'sd4, 1'b1, '{1'b0, 16'sd9830, 16'sd13107, 16'd0}},
    '{16'd4000, 16'd32767, -16'sd3, -16'sd4, 1'b1, '{1'b0, -16'sd9830, -16'sd13107, 16'd0}},
    '{16'd4000, 16'd32767, 16'sd1, 16'sd1, 1'b1, '{1'b0, 16'sd16384, 16'sd16384, 16'd0}},
    '{16'd4000, 16'd32767, -16'sd1, 16'sd0, 1'b1, '{1'b0, -16'sd16384, 16'sd0, 16'd0}},
    '{16'd4000, 16'd32767, 16'sd12345, -16'sd23456, 1'b0, '0},
    '{16'd5000, 16'd5000, 16'sd5001, 16'sd0, 1'b1, '{1'b1, 16'sd16384, 16'sd0, 16'd32768}},
    '{16'd5000, 16'd5000, 16'sd5000, 16'sd0, 1'b1, '{1'b0, 16'sd16384, 16'sd0, 16'd0}},
    '{16'd20000, 16'd10000, 16'sd0, 16'sd25000, 1'b1,
      '{1'b1, 16'sd0, 16'sd16384, 16'd32768}},
    '{16'd20000, 16'd10000, -16'sd15000, 16'sd0, 1'b1, '{1'b0, -16'sd16384, 16'sd0, 16'd0}},
    '{16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, '{1'b0, 16'sd0, 16'sd0, 16'd0}},
    '{16'd0, 16'd0, 16'sd1, 16'sd0, 1'b1, '{1'b1, 16'sd16384, 16'sd0, 16'd32768}},
    '{16'd0, 16'd65535, 16'sh8000, 16'sd0, 1'b1, '{1'b1, -16'sd16384, 16'sd0, 16'd16384}},
    '{16'd0, 16'd65535, 16'sd0, -16'sd1, 1'b1, '{1'b1, 16'sd0, -16'sd16384, 16'd0}},
    '{16'hFFFF, 16'd46341, 16'sh8000, 16'sd0, 1'b1, '{1'b1, -16'sd16384, 16'sd0, 16'd2}},
    '{16'hFFFF, 16'd46341, 16'sd32767, 16'sd0, 1'b1, '{1'b0, 16'sd16384, 16'sd0, 16'd0}}
  };

  // Exact floor square root, two radicand bits per step
  function automatic longint stick_length(longint sum_sq);
    longint rem;
    longint root;
    longint probe;
    rem   = sum_sq;
    root  = 0;
    probe = longint'(1) << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // One Q2.14 direction component, truncated toward zero; zero length gives zero
  function automatic logic signed [OUT_W-1:0] unit_component(logic signed [IN_W-1:0] c,
                                                             longint len);
    longint mag;
    longint q;
    if (len == 0) return '0;
    mag = c;
    if (mag < 0) mag = -mag;
    q = (mag << DIR_FRAC) / len;
    if (c < 0) q = -q;
    return q[OUT_W-1:0];
  endfunction

  // Full result for one sample under the current register setting
  function automatic res_t deadzone_result(logic signed [IN_W-1:0] sx,
                                           logic signed [IN_W-1:0] sy);
    longint len;
    longint reach;
    longint span;
    longint norm;
    res_t   r;
    len              = stick_length(longint'(sx) * sx + longint'(sy) * sy);
    r.active         = (len > longint'(dz_model));
    r.dir_x          = unit_component(sx, len);
    r.dir_y          = unit_component(sy, len);
    r.norm_magnitude = '0;
    if (r.active) begin
      if (fs_model <= dz_model) begin
        // Already past full scale: saturate to 1.0
        r.norm_magnitude = MAG_ONE;
      end else begin
        reach = (len > longint'(fs_model)) ? longint'(fs_model) : len;
        span  = longint'(fs_model) - longint'(dz_model);
        norm  = ((reach - longint'(dz_model)) << MAG_FRAC) / span;
        if (norm > longint'(MAG_ONE)) norm = longint'(MAG_ONE);
        r.norm_magnitude = norm[OUT_W-1:0];
      end
    end
    return r;
  endfunction

  // Hold off the sender until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Drain, then write both registers back to back; keep the bench copy in step
  task automatic set_config(logic [CFG_DATA_W-1:0] dz_w, logic [CFG_DATA_W-1:0] fs_w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DEADZONE;
    cfg_wdata <= dz_w;
    @(posedge clk);
    cfg_idx   <= REG_FULL_SCALE;
    cfg_wdata <= fs_w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    dz_model   = dz_w[DZ_W-1:0];
    fs_model   = fs_w;
    dz_written = dz_w;
    fs_written = fs_w;
  endtask

  // Offer one sample, wait for its transfer, then record what the unit owes for it.
  // The sender runs in bursts; a gap, if due, comes before the sample.
  task automatic send_sample(logic signed [IN_W-1:0] sx, logic signed [IN_W-1:0] sy,
                             bit typed, res_t want);
    pending_t owed;
    if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_ch.valid   <= 1'b1;
    in_ch.stick_x <= sx;
    in_ch.stick_y <= sy;
    do @(posedge clk); while (!in_ch.ready);
    owed.sx   = sx;
    owed.sy   = sy;
    owed.want = typed ? want : deadzone_result(sx, sy);
    pending_results.push_back(owed);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
    end
  endtask

  // Draw a sample: full-range noise, plus lengths right at the dead zone
  // and full scale edges, tiny vectors, corner values and points inside a random box
  task automatic random_sample(output logic signed [IN_W-1:0] sx,
                               output logic signed [IN_W-1:0] sy);
    int                     mode;
    int                     reach;
    logic signed [IN_W-1:0] a;
    logic signed [IN_W-1:0] b;
    mode = $urandom_range(0, 9);
    case (mode)
      3, 4, 5: begin
        reach = (mode == 5) ? int'(fs_model) : int'(dz_model);
        reach = reach + int'($urandom_range(0, 4)) - 2;
        if (reach < 0) reach = 0;
        if (reach > 32767) reach = 32767;
        a = reach[IN_W-1:0];
        b = '0;
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) begin
          b = a;
          a = '0;
        end
      end
      6: begin
        a = IN_W'(int'($urandom_range(0, 16)) - 8);
        b = IN_W'(int'($urandom_range(0, 16)) - 8);
      end
      7: begin
        a = corners[$urandom_range(0, 5)];
        b = corners[$urandom_range(0, 5)];
      end
      8, 9: begin
        reach = $urandom_range(0, 32767);
        a = IN_W'($urandom_range(0, reach));
        b = IN_W'($urandom_range(0, reach));
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
      end
      default: begin
        a = IN_W'($urandom);
        b = IN_W'($urandom);
      end
    endcase
    sx = a;
    sy = b;
  endtask

  // Stimulus: reset, directed table, random phases, then drain and report
  initial begin
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_DEADZONE;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.stick_x <= '0;
    in_ch.stick_y <= '0;
    dz_model   = DZ_RESET;
    fs_model   = FS_RESET;
    dz_written = CFG_DATA_W'(DZ_RESET);
    fs_written = CFG_DATA_W'(FS_RESET);
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;
    phase_dz[7] = 16'($urandom_range(0, 65535));
    phase_fs[7] = 16'($urandom_range(1, 46341));
    phase_dz[8] = 16'($urandom_range(0, 65535));
    phase_fs[8] = 16'($urandom_range(0, 65535));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows start on the reset values; write registers only on a change
    foreach (script[i]) begin
      if (script[i].dz_w != dz_written || script[i].fs_w != fs_written)
        set_config(script[i].dz_w, script[i].fs_w);
      send_sample(script[i].sx, script[i].sy, script[i].typed, script[i].want);
    end

    // Random phases; each setting change drains the pipe first, and now and then
    // the sender also pauses mid-phase until everything is back
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(phase_dz[ph], phase_fs[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_sample(sx, sy);
        send_sample(sx, sy, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    // Drop valid, collect the rest, then watch a while for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: drive ready from a 16-bit stall mask, each redrawn mask one of four kinds;
  // some masks are all ones, giving stretches with no stalls at all
  initial begin
    logic [15:0] stall_mask;
    int          slot;
    out_ch.ready <= 1'b0;
    stall_mask = '1;
    slot       = 0;
    forever begin
      @(posedge clk);
      if (slot % 128 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom) | 16'h0001;
          2: stall_mask = 16'($urandom & $urandom) | 16'h0001;
          default: stall_mask = 16'h5555;
        endcase
      end
      out_ch.ready <= stall_mask[slot % 16];
      slot++;
    end
  end

  task automatic check_field(string fname, pending_t owed, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch for sample (%0d,%0d): expected %0d, actual %0d",
               $time, fname, owed.sx, owed.sy, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer against the oldest owed result
  always @(posedge clk) begin
    pending_t owed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual dir (%0d,%0d) mag %0d",
                 $time, out_ch.dir_x, out_ch.dir_y, out_ch.norm_magnitude);
        mismatches++;
      end else begin
        owed = pending_results.pop_front();
        check_field("active", owed, owed.want.active, out_ch.active);
        check_field("dir_x", owed, owed.want.dir_x, out_ch.dir_x);
        check_field("dir_y", owed, owed.want.dir_y, out_ch.dir_y);
        check_field("norm_magnitude", owed, owed.want.norm_magnitude, out_ch.norm_magnitude);
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
